### rtl/microwire_eeprom_master_macros.svh
// Assertion macros used by the Microwire EEPROM master sequencer RTL.
`ifndef MICROWIRE_EEPROM_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_MACROS_SVH

// Clocked assertion, skipped while reset is high.
`define MWE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define MWE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/mwe_pkg.sv
// Shared types and constants of the Microwire EEPROM master.
`timescale 1ns / 1ps
`default_nettype none
package mwe_pkg;

   localparam int MAX_ADDR_BITS = 12;
   localparam int MIN_ADDR_BITS = 6;
   localparam int DATA_W        = 16;
   localparam int ABITS_W       = 4;
   localparam int TMO_W         = 14;
   localparam int OP_W          = 3;
   // two opcode bits, address, data
   localparam int SHIFT_W       = 2 + MAX_ADDR_BITS + DATA_W;
   localparam int CNT_W         = $clog2(SHIFT_W + 1);
   localparam int IDX_W         = $clog2(SHIFT_W);

   localparam logic [TMO_W-1:0]   TIMEOUT_RESET   = TMO_W'(10000);
   localparam logic [ABITS_W-1:0] ADDR_BITS_RESET = ABITS_W'(MIN_ADDR_BITS);

   // command codes
   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
   localparam logic [OP_W-1:0] OP_ERAL  = 3'd3;
   localparam logic [OP_W-1:0] OP_EWEN  = 3'd4;
   localparam logic [OP_W-1:0] OP_EWDS  = 3'd5;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TMO_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_16   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd2;

   typedef struct packed {
      logic [ABITS_W-1:0] addr_bits;
      logic               word_16;
      logic [TMO_W-1:0]   busy_timeout;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic [MAX_ADDR_BITS-1:0] address;
      logic [DATA_W-1:0]        write_data;
      logic                     do_pin;
   } req_type;

   typedef struct packed {
      logic              cs_pin;
      logic              sk_pin;
      logic              di_pin;
      logic              busy_res;
      logic [DATA_W-1:0] read_data;
      logic              read_valid;
      logic              timeout_error;
      logic              done_res;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/mwe_csr.sv
// Configuration registers of the Microwire EEPROM master.
`timescale 1ns / 1ps
`default_nettype none
module mwe_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [mwe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [mwe_pkg::CSR_DATA_W-1:0]    csr_data,
   output mwe_pkg::cfg_type                  cfg
);

   mwe_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // update the addressed register, ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mwe_pkg::CSR_ADDR_BITS: cfg_in.addr_bits    = csr_data[mwe_pkg::ABITS_W-1:0];
            mwe_pkg::CSR_WORD_16:   cfg_in.word_16      = csr_data[0];
            mwe_pkg::CSR_TIMEOUT:   cfg_in.busy_timeout = csr_data[mwe_pkg::TMO_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addr_bits    <= mwe_pkg::ADDR_BITS_RESET;
         cfg_ff.word_16      <= 1'b0;
         cfg_ff.busy_timeout <= mwe_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mwe_engine.sv
// Frame sequencer of the Microwire EEPROM master: one half clock period per request.
`timescale 1ns / 1ps
`default_nettype none
`include "microwire_eeprom_master_macros.svh"
module mwe_engine (
   input  wire               clock,
   input  wire               reset,
   input  wire               fire,
   input  mwe_pkg::req_type  req,
   input  mwe_pkg::cfg_type  cfg,
   output mwe_pkg::rsp_type  rsp
);

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_START   = 5'd1;
   localparam logic [4:0] PH_TX_LO   = 5'd2;
   localparam logic [4:0] PH_TX_HI   = 5'd3;
   localparam logic [4:0] PH_DUM_LO  = 5'd4;
   localparam logic [4:0] PH_DUM_HI  = 5'd5;
   localparam logic [4:0] PH_RX_LO   = 5'd6;
   localparam logic [4:0] PH_RX_HI   = 5'd7;
   localparam logic [4:0] PH_W_LO    = 5'd8;
   localparam logic [4:0] PH_W_CSLO  = 5'd9;
   localparam logic [4:0] PH_W_CSHI  = 5'd10;
   localparam logic [4:0] PH_W_SKHI  = 5'd11;
   localparam logic [4:0] PH_POLL    = 5'd12;
   localparam logic [4:0] PH_POLL_HI = 5'd13;
   localparam logic [4:0] PH_END_LO  = 5'd14;
   localparam logic [4:0] PH_END_HI  = 5'd15;
   localparam logic [4:0] PH_FIN     = 5'd16;

   localparam int SW = mwe_pkg::SHIFT_W;
   localparam int CW = mwe_pkg::CNT_W;
   localparam int AW = mwe_pkg::MAX_ADDR_BITS;
   localparam int DW = mwe_pkg::DATA_W;
   localparam int TW = mwe_pkg::TMO_W;

   logic [4:0]                phase_ff, phase_in;
   logic [CW-1:0]             bit_count_ff, bit_count_in;
   logic [SW-1:0]             out_shift_ff, out_shift_in;
   logic [DW-1:0]             in_shift_ff, in_shift_in;
   logic [TW-1:0]             poll_count_ff, poll_count_in;
   logic [2:0]                pins_ff, pins_in;   // {di, sk, cs}
   logic [mwe_pkg::OP_W-1:0]  active_ff, active_in;

   logic [mwe_pkg::ABITS_W-1:0] eff_a;
   logic [CW-1:0]               word_len;
   logic [AW-1:0]               addr_m;
   logic [DW-1:0]               wdata_m;
   logic [SW-1:0]               hdr;
   logic [CW-1:0]               tx_idx;
   logic [CW-1:0]               bc_dec;
   logic                        tx_di;

   // clamp the address width and build the frame words
   always_comb begin
      if (cfg.addr_bits < mwe_pkg::ABITS_W'(mwe_pkg::MIN_ADDR_BITS)) begin
         eff_a = mwe_pkg::ABITS_W'(mwe_pkg::MIN_ADDR_BITS);
      end else if (cfg.addr_bits > mwe_pkg::ABITS_W'(AW)) begin
         eff_a = mwe_pkg::ABITS_W'(AW);
      end else begin
         eff_a = cfg.addr_bits;
      end
      word_len = cfg.word_16 ? CW'(16) : CW'(8);
      addr_m   = req.address & ~({AW{1'b1}} << eff_a);
      wdata_m  = cfg.word_16 ? req.write_data : {8'h00, req.write_data[7:0]};
      hdr      = (SW'(1) << eff_a) | SW'(addr_m);
   end

   // pick the next frame bit, MSB first
   always_comb begin
      tx_idx = bit_count_ff - CW'(1);
      bc_dec = (bit_count_ff != '0) ? bit_count_ff - CW'(1) : bit_count_ff;
      if (bit_count_ff != '0 && bit_count_ff <= CW'(SW)) begin
         tx_di = out_shift_ff[tx_idx[mwe_pkg::IDX_W-1:0]];
      end else begin
         tx_di = 1'b0;
      end
   end

   // advance the sequencer by one half period
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      out_shift_in  = out_shift_ff;
      in_shift_in   = in_shift_ff;
      poll_count_in = poll_count_ff;
      pins_in       = pins_ff;
      active_in     = active_ff;
      rsp           = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req.opcode >= mwe_pkg::OP_READ && req.opcode <= mwe_pkg::OP_EWDS) begin
               active_in    = req.opcode;
               bit_count_in = CW'(eff_a) + CW'(2);
               unique case (req.opcode)
                  mwe_pkg::OP_READ:  out_shift_in = (SW'(2) << eff_a) | SW'(addr_m);
                  mwe_pkg::OP_WRITE: begin
                     out_shift_in = (hdr << word_len) | SW'(wdata_m);
                     bit_count_in = CW'(eff_a) + CW'(2) + word_len;
                  end
                  mwe_pkg::OP_ERAL:  out_shift_in = SW'(1) << (eff_a - 4'd1);
                  mwe_pkg::OP_EWEN:  out_shift_in = SW'(3) << (eff_a - 4'd2);
                  default:           out_shift_in = '0;
               endcase
               pins_in  = 3'b101;
               phase_in = PH_START;
            end else begin
               pins_in = 3'b000;
            end
         end
         PH_START: begin
            pins_in  = 3'b111;
            phase_in = PH_TX_LO;
         end
         PH_TX_LO: begin
            pins_in  = {tx_di, 2'b01};
            phase_in = PH_TX_HI;
         end
         PH_TX_HI: begin
            pins_in      = {pins_ff[2], 2'b11};
            bit_count_in = bc_dec;
            if (bc_dec != '0) begin
               phase_in = PH_TX_LO;
            end else if (active_ff == mwe_pkg::OP_READ) begin
               phase_in = PH_DUM_LO;
            end else if (active_ff == mwe_pkg::OP_WRITE || active_ff == mwe_pkg::OP_ERAL) begin
               phase_in = PH_W_LO;
            end else begin
               phase_in = PH_FIN;
            end
         end
         PH_FIN: begin
            pins_in      = 3'b010;
            rsp.done_res = 1'b1;
            phase_in     = PH_IDLE;
         end
         PH_DUM_LO: begin
            pins_in  = 3'b001;
            phase_in = PH_DUM_HI;
         end
         PH_DUM_HI: begin
            pins_in      = 3'b011;
            bit_count_in = word_len;
            in_shift_in  = '0;
            phase_in     = PH_RX_LO;
         end
         PH_RX_LO: begin
            pins_in  = 3'b001;
            phase_in = PH_RX_HI;
         end
         PH_RX_HI: begin
            in_shift_in  = {in_shift_ff[DW-2:0], req.do_pin};
            pins_in      = 3'b011;
            bit_count_in = bc_dec;
            if (bc_dec == '0) begin
               // reuse the ready path to close the frame
               phase_in      = PH_POLL;
               poll_count_in = '0;
               active_in     = mwe_pkg::OP_READ;
            end else begin
               phase_in = PH_RX_LO;
            end
         end
         PH_W_LO: begin
            pins_in  = 3'b001;
            phase_in = PH_W_CSLO;
         end
         PH_W_CSLO: begin
            pins_in  = 3'b000;
            phase_in = PH_W_CSHI;
         end
         PH_W_CSHI: begin
            pins_in  = 3'b001;
            phase_in = PH_W_SKHI;
         end
         PH_W_SKHI: begin
            pins_in       = 3'b011;
            poll_count_in = '0;
            phase_in      = PH_POLL;
         end
         PH_POLL: begin
            if (active_ff == mwe_pkg::OP_READ || req.do_pin) begin
               pins_in  = 3'b010;
               phase_in = PH_END_LO;
            end else if (poll_count_ff >= cfg.busy_timeout) begin
               pins_in           = 3'b000;
               rsp.timeout_error = 1'b1;
               rsp.done_res      = 1'b1;
               phase_in          = PH_IDLE;
            end else begin
               pins_in  = 3'b001;
               phase_in = PH_POLL_HI;
            end
         end
         PH_POLL_HI: begin
            pins_in = 3'b011;
            if (poll_count_ff != {TW{1'b1}}) begin
               poll_count_in = poll_count_ff + TW'(1);
            end
            phase_in = PH_POLL;
         end
         PH_END_LO: begin
            pins_in  = 3'b000;
            phase_in = PH_END_HI;
         end
         PH_END_HI: begin
            pins_in      = 3'b010;
            rsp.done_res = 1'b1;
            if (active_ff == mwe_pkg::OP_READ) begin
               rsp.read_valid = 1'b1;
               rsp.read_data  = in_shift_ff;
            end
            phase_in = PH_IDLE;
         end
         default: begin
            pins_in  = 3'b000;
            phase_in = PH_IDLE;
         end
      endcase

      rsp.cs_pin   = pins_in[0];
      rsp.sk_pin   = pins_in[1];
      rsp.di_pin   = pins_in[2];
      rsp.busy_res = (phase_in != PH_IDLE);
   end

   // hold state unless a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         out_shift_ff  <= '0;
         in_shift_ff   <= '0;
         poll_count_ff <= '0;
         pins_ff       <= '0;
         active_ff     <= mwe_pkg::OP_TICK;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         out_shift_ff  <= out_shift_in;
         in_shift_ff   <= in_shift_in;
         poll_count_ff <= poll_count_in;
         pins_ff       <= pins_in;
         active_ff     <= active_in;
      end
   end

   `MWE_ASSERT(a_state_holds, clock, reset, !fire |=> $stable(phase_ff),
      "phase moved without a request")
   `MWE_ASSERT(a_tx_count, clock, reset,
      (phase_ff == PH_TX_LO) |-> (bit_count_ff != '0 && bit_count_ff <= CW'(SW)),
      "frame bit count out of range")
   `MWE_ASSERT(a_poll_step, clock, reset,
      (fire && phase_ff == PH_POLL_HI && poll_count_ff != {TW{1'b1}})
         |=> (poll_count_ff == $past(poll_count_ff) + TW'(1)),
      "poll counter did not advance")

endmodule
`default_nettype wire

### rtl/microwire_eeprom_master.sv
// Top level of the Microwire EEPROM master: request and result registers around the sequencer.
//
//  channel   dir   handshake             payload
//  req_      in    req_tvalid/tready     tuser opcode, tdata address/write_data/do_pin
//  rsp_      out   rsp_tvalid/tready     tdata pins/busy/read_data/timeout, tuser, tlast
//  csr_      in    csr_valid/csr_ready   csr_index, csr_data
//
// One request per cycle while the result register has room; each result passes through
// the request register and then the result register.
// Reset clears the sequencer and both valid flags and loads the configuration registers' defaults.
// While rsp_tready is low the result register holds; the request register still
// fills, and req_tready falls only once both registers are full.
`timescale 1ns / 1ps
`default_nettype none
module microwire_eeprom_master (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // opcode[2:0]
   input  wire  [2:0]                      req_tuser,
   // address[11:0], write_data[27:12], do_pin[28], zero[31:29]
   input  wire  [31:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // cs_pin[0], sk_pin[1], di_pin[2], busy_res[3], read_data[19:4],
   // timeout_error[20], zero[23:21]
   output logic [23:0]                     rsp_tdata,
   // read_valid[0]
   output logic                            rsp_tuser,
   // done_res
   output logic                            rsp_tlast,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [mwe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [mwe_pkg::CSR_DATA_W-1:0]  csr_data
);

   mwe_pkg::cfg_type cfg;
   mwe_pkg::req_type req_ff, req_in;
   mwe_pkg::rsp_type rsp_ff, rsp_next;
   logic             req_v_ff, rsp_v_ff;
   logic             out_free, fire;

   mwe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mwe_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // unpack the incoming request
   always_comb begin
      req_in.opcode     = req_tuser;
      req_in.address    = req_tdata[11:0];
      req_in.write_data = req_tdata[27:12];
      req_in.do_pin     = req_tdata[28];
   end

   // move a request into the result register when it has room
   assign out_free   = !rsp_v_ff || rsp_tready;
   assign fire       = req_v_ff && out_free;
   assign req_tready = !req_v_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_v_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_v_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   // pack the result
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.timeout_error, rsp_ff.read_data, rsp_ff.busy_res,
                        rsp_ff.di_pin, rsp_ff.sk_pin, rsp_ff.cs_pin};
   assign rsp_tuser  = rsp_ff.read_valid;
   assign rsp_tlast  = rsp_ff.done_res;

endmodule
`default_nettype wire
